/* rtl/ffs_pkg.sv */
// shared constants, types and config defaults of the fixed frame synchronizer
`timescale 1ns / 1ps
`default_nettype none

package ffs_pkg;

  // frame geometry
  localparam int unsigned FRAME_LEN = 2052;
  localparam int unsigned HDR_LEN   = 10;
  localparam int unsigned HIST_LEN  = HDR_LEN - 1;

  // the delay memory returns the byte written this many transfers ago
  localparam int unsigned RAM_DEPTH = FRAME_LEN + HDR_LEN - 2;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  // counters that must hold FRAME_LEN itself
  localparam int unsigned CNT_W  = $clog2(FRAME_LEN + 1);
  localparam int unsigned FILL_W = $clog2(HDR_LEN + 1);

  // configuration register reset values
  localparam logic [15:0] SYNC_WORD_RST   = 16'h009F;
  localparam logic [15:0] LENGTH_WORD_RST = 16'h07F9;
  localparam logic [31:0] MARKER_WORD_RST = 32'h706F6C61;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC   = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_MARKER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [15:0] length_word;
    logic [31:0] marker_word;
  } cfg_t;

  // per-transfer emit decision from the header hunt
  typedef struct packed {
    logic emit;
    logic first;
    logic last;
  } emit_t;

endpackage

`default_nettype wire

/* rtl/fixed_frame_synchronizer_core.sv */
// top level of the fixed frame synchronizer: config, delay memory and output stages
`timescale 1ns / 1ps
`default_nettype none

// throughput: one byte per cycle unless the output stalls, set by the single-port
//   read-first delay memory; a released frame byte leaves via the memory stage and
//   output register, FRAME_LEN + 8 transfers after that byte came in
// reset: control state and config registers load at once; the delay memory
//   needs no clearing as only bytes written since reset are ever read out
module fixed_frame_synchronizer_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ffs_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ffs_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  ffs_pkg::cfg_t              cfg_q;
  ffs_pkg::emit_t             emit;
  logic                       accept, advance;
  logic [ffs_pkg::ADDR_W-1:0] wr_ptr_q;
  logic [7:0]                 rd_byte;
  logic                       p_valid_q, p_first_q, p_last_q;
  logic                       o_valid_q;
  ffs_pkg::out_item_t         o_data_q;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word   <= ffs_pkg::SYNC_WORD_RST;
      cfg_q.length_word <= ffs_pkg::LENGTH_WORD_RST;
      cfg_q.marker_word <= ffs_pkg::MARKER_WORD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ffs_pkg::CFG_SYNC:   cfg_q.sync_word   <= cfg_data_i[15:0];
        ffs_pkg::CFG_LENGTH: cfg_q.length_word <= cfg_data_i[15:0];
        ffs_pkg::CFG_MARKER: cfg_q.marker_word <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: the memory stage holds while the output register is blocked
  assign advance    = !o_valid_q || !out_stall_i;
  assign in_stall_o = p_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  ffs_hunt u_hunt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .emit_o   (emit)
  );

  // circular write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
    end else if (accept) begin
      if (wr_ptr_q == ffs_pkg::ADDR_W'(ffs_pkg::RAM_DEPTH - 1)) begin
        wr_ptr_q <= '0;
      end else begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
    end
  end

  ffs_delay_ram u_ram (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (wr_ptr_q),
    .wdata_i (in_data_i.data_byte),
    .rdata_o (rd_byte)
  );

  // memory stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (accept) begin
      p_valid_q <= emit.emit;
    end else if (advance) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_first_q <= emit.first;
      p_last_q  <= emit.last;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (advance) begin
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      o_data_q.out_byte    <= rd_byte;
      o_data_q.frame_start <= p_first_q;
      o_data_q.frame_last  <= p_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

  // a frame is far longer than one byte
  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.frame_start && out_data_o.frame_last))
    else $error("frame start and last on the same byte");

  // a transfer into a full memory stage must drain it the same cycle
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && p_valid_q) |-> advance)
    else $error("pending frame byte overwritten");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q <= ffs_pkg::ADDR_W'(ffs_pkg::RAM_DEPTH - 1))
    else $error("delay pointer out of range");

endmodule

`default_nettype wire

/* rtl/ffs_delay_ram.sv */
// byte delay memory: one write port with read-first registered data
`timescale 1ns / 1ps
`default_nettype none

module ffs_delay_ram (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [ffs_pkg::ADDR_W-1:0] addr_i,
  input  wire logic [7:0]                 wdata_i,
  output logic      [7:0]                 rdata_o
);

  logic [7:0] mem [ffs_pkg::RAM_DEPTH];
  logic [7:0] rdata_q;

  // old contents come out while the new byte goes in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/ffs_hunt.sv */
// header window, candidate tracking and frame emit counter
`timescale 1ns / 1ps
`default_nettype none

module ffs_hunt (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire ffs_pkg::in_item_t item_i,
  input  wire ffs_pkg::cfg_t     cfg_i,
  output ffs_pkg::emit_t         emit_o
);

  logic [7:0]                 win_q [ffs_pkg::HIST_LEN];
  logic [ffs_pkg::FILL_W-1:0] fill_q, fill_d, fill_eff;
  logic                       cand_q, cand_d, cand_eff;
  logic [ffs_pkg::CNT_W-1:0]  age_q, age_d, age_eff, age_inc;
  logic [ffs_pkg::CNT_W-1:0]  rem_q, rem_d, rem_pre;
  logic [15:0]                sync_seen, length_seen;
  logic [31:0]                marker_seen;
  logic                       hdr_hit, confirm;

  // header fields as they sit in the window once this byte is in
  assign sync_seen   = {win_q[8], win_q[7]};
  assign length_seen = {win_q[4], win_q[3]};
  assign marker_seen = {win_q[2], win_q[1], win_q[0], item_i.data_byte};

  always_comb begin
    // a restart drops the candidate and the warm-up count
    cand_eff = item_i.new_file ? 1'b0 : cand_q;
    age_eff  = item_i.new_file ? '0 : age_q;
    fill_eff = item_i.new_file ? '0 : fill_q;

    fill_d = (fill_eff < ffs_pkg::FILL_W'(ffs_pkg::HDR_LEN)) ? fill_eff + 1'b1 : fill_eff;

    hdr_hit = (fill_d >= ffs_pkg::FILL_W'(ffs_pkg::HDR_LEN)) &&
              (sync_seen == cfg_i.sync_word) &&
              (length_seen == cfg_i.length_word) &&
              (marker_seen == cfg_i.marker_word);

    // candidate update
    age_inc = age_eff + 1'b1;
    confirm = 1'b0;
    cand_d  = cand_eff;
    age_d   = age_eff;
    if (cand_eff) begin
      if (hdr_hit) begin
        age_d = '0;
      end else if (age_inc >= ffs_pkg::CNT_W'(ffs_pkg::FRAME_LEN - 1)) begin
        cand_d  = 1'b0;
        age_d   = '0;
        confirm = 1'b1;
      end else begin
        age_d = age_inc;
      end
    end else if (hdr_hit) begin
      cand_d = 1'b1;
      age_d  = '0;
    end

    // emit counter
    rem_pre      = confirm ? ffs_pkg::CNT_W'(ffs_pkg::FRAME_LEN) : rem_q;
    emit_o.emit  = (rem_pre != '0);
    emit_o.first = (rem_pre == ffs_pkg::CNT_W'(ffs_pkg::FRAME_LEN));
    emit_o.last  = (rem_pre == ffs_pkg::CNT_W'(1));
    rem_d        = emit_o.emit ? rem_pre - 1'b1 : rem_pre;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cand_q <= 1'b0;
      age_q  <= '0;
      rem_q  <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      cand_q <= cand_d;
      age_q  <= age_d;
      rem_q  <= rem_d;
    end
  end

  // last nine bytes, newest first
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q[0] <= item_i.data_byte;
      for (int k = 1; k < ffs_pkg::HIST_LEN; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire
